// ===== rtl/g2pm_pkg.sv =====
// Shared types and constants of the 2x2 grid pattern matcher.
package g2pm_pkg;

    localparam int COLOR_W = 3;
    localparam int SIZE_W  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 12;
    localparam int NUM_CELLS = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [COLOR_W-1:0] color_t;

    // One column of the 2x2 window: the cell from the row above and the one below.
    typedef struct packed {
        color_t top;
        color_t bottom;
    } color_pair_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH           = 3'd0,
        REG_GRID_HEIGHT          = 3'd1,
        REG_PATTERN_TOP_LEFT     = 3'd2,
        REG_PATTERN_TOP_RIGHT    = 3'd3,
        REG_PATTERN_BOTTOM_LEFT  = 3'd4,
        REG_PATTERN_BOTTOM_RIGHT = 3'd5
    } cfg_reg_t;

    localparam logic RESULT_MATCH = 1'b0;
    localparam logic RESULT_TOTAL = 1'b1;

endpackage

// ===== rtl/g2pm_window_cell.sv =====
// One column cell of the 2x2 window chain: holds a colour pair and compares it.
module g2pm_window_cell
    import g2pm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  color_pair_t pair_in,
    input  color_pair_t pattern,
    output color_pair_t pair_out,
    output logic        hit
);

    color_t top_reg;
    color_t bottom_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            top_reg <= pair_in.top;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bottom_reg <= '0;
        end else if (advance) begin
            bottom_reg <= pair_in.bottom;
        end
    end

    assign pair_out.top    = top_reg;
    assign pair_out.bottom = bottom_reg;
    assign hit = (top_reg == pattern.top) && (bottom_reg == pattern.bottom);

endmodule

// ===== rtl/g2pm_line_buf.sv =====
// Line buffer holding the row above: one write port, one registered read port.
module g2pm_line_buf
    import g2pm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  color_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output color_t        rd_data
);

    color_t mem [DEPTH];
    color_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/grid_2x2_pattern_matcher_core.sv =====
// Top level of the 2x2 grid pattern matcher: counters, window chain and result stage.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------------
//  s_       | s_valid/s_ready  | s_cell_color
//  m_       | m_valid/m_ready  | m_result_kind, m_match_column, m_match_row,
//           |                  | m_match_total, m_last_of_run
//  cfg_     | cfg_wr_en        | cfg_index, cfg_wr_data
//
//  One cell per clock while s_ready is high; the window stage feeds the result register.
//  A cell with a match and the frame total holds the result register for two beats.
//  The line buffer is read one column ahead, so each cell costs one read and one write.
//  aresetn (synchronous) clears counters, match count and pipeline valids;
//  the line buffer is left as it is and needs no clearing pass.
//  A stalled m_ready backs up through the window stage into s_ready.
module grid_2x2_pattern_matcher_core
    import g2pm_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COLOR_W-1:0]    s_cell_color,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_result_kind,
    output logic [POS_W-1:0]      m_match_column,
    output logic [POS_W-1:0]      m_match_row,
    output logic [COUNT_W-1:0]    m_match_total,
    output logic                  m_last_of_run
);

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Configuration registers
    logic [SIZE_W-1:0] grid_width_reg;
    logic [SIZE_W-1:0] grid_height_reg;
    color_t            pat_tl_reg, pat_tr_reg, pat_bl_reg, pat_br_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= SIZE_W'(2);
            grid_height_reg <= SIZE_W'(2);
            pat_tl_reg      <= '0;
            pat_tr_reg      <= '0;
            pat_bl_reg      <= '0;
            pat_br_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GRID_WIDTH:           grid_width_reg  <= cfg_wr_data;
                REG_GRID_HEIGHT:          grid_height_reg <= cfg_wr_data;
                REG_PATTERN_TOP_LEFT:     pat_tl_reg      <= cfg_wr_data[COLOR_W-1:0];
                REG_PATTERN_TOP_RIGHT:    pat_tr_reg      <= cfg_wr_data[COLOR_W-1:0];
                REG_PATTERN_BOTTOM_LEFT:  pat_bl_reg      <= cfg_wr_data[COLOR_W-1:0];
                REG_PATTERN_BOTTOM_RIGHT: pat_br_reg      <= cfg_wr_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Last column and row index in use, sizes saturated to 2..MAX
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;

    always_comb begin
        if (grid_width_reg < SIZE_W'(2)) begin
            w_last = CW'(1);
        end else if (32'(grid_width_reg) > 32'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(32'(grid_width_reg) - 32'd1);
        end
        if (grid_height_reg < SIZE_W'(2)) begin
            h_last = RW'(1);
        end else if (32'(grid_height_reg) > 32'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(32'(grid_height_reg) - 32'd1);
        end
    end

    // Handshake
    logic a_valid_reg, a_valid_next;
    logic b_match_pend_reg, b_match_pend_next;
    logic b_total_pend_reg, b_total_pend_next;
    logic b_free, a_move, s_accept, m_pop;

    assign m_valid  = b_match_pend_reg || b_total_pend_reg;
    assign m_pop    = m_valid && m_ready;
    assign b_free   = !m_valid || (m_ready && (b_match_pend_reg ^ b_total_pend_reg));
    assign a_move   = a_valid_reg && b_free;
    assign s_ready  = !a_valid_reg || b_free;
    assign s_accept = s_valid && s_ready;

    // Column and row counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          last_col, last_row, frame_end;

    assign last_col  = col_reg >= w_last;
    assign last_row  = row_reg >= h_last;
    assign frame_end = last_col && last_row;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            priority if (frame_end) begin
                col_next = '0;
                row_next = '0;
            end else if (last_col) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line buffer: write this beat's cell, prefetch the next column's entry
    color_t above_color;

    g2pm_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (col_reg),
        .wr_data (s_cell_color),
        .rd_addr (col_next),
        .rd_data (above_color)
    );

    // Window chain: right cell takes the new column, left cell takes the right one
    color_pair_t chain [NUM_CELLS+1];
    color_pair_t cell_pattern [NUM_CELLS];
    logic [NUM_CELLS-1:0] cell_hit;

    assign chain[NUM_CELLS].top    = above_color;
    assign chain[NUM_CELLS].bottom = s_cell_color;
    assign cell_pattern[0] = '{top: pat_tl_reg, bottom: pat_bl_reg};
    assign cell_pattern[1] = '{top: pat_tr_reg, bottom: pat_br_reg};

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        g2pm_window_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (s_accept),
            .pair_in  (chain[k+1]),
            .pattern  (cell_pattern[k]),
            .pair_out (chain[k]),
            .hit      (cell_hit[k])
        );
    end

    // Window stage: position and flags of the cell held in the chain
    logic          a_check_reg;
    logic          a_frame_end_reg;
    logic [CW-1:0] a_col_reg;
    logic [RW-1:0] a_row_reg;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_accept) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_check_reg     <= (col_reg != '0) && (row_reg != '0);
            a_frame_end_reg <= frame_end;
            a_col_reg       <= col_reg;
            a_row_reg       <= row_reg;
        end
    end

    // Match count and result stage
    logic               match;
    logic [COUNT_W-1:0] found_reg, found_next;
    logic [COUNT_W-1:0] found_bumped;
    logic [COUNT_W-1:0] b_count_reg;
    logic [POS_W-1:0]   b_col_reg, b_row_reg;

    assign match        = a_check_reg && (&cell_hit);
    assign found_bumped = (match && (found_reg != COUNT_MAX)) ? found_reg + COUNT_W'(1)
                                                              : found_reg;

    always_comb begin
        found_next        = found_reg;
        b_match_pend_next = b_match_pend_reg;
        b_total_pend_next = b_total_pend_reg;
        if (m_pop) begin
            if (b_match_pend_reg) begin
                b_match_pend_next = 1'b0;
            end else begin
                b_total_pend_next = 1'b0;
            end
        end
        if (a_move) begin
            b_match_pend_next = match;
            b_total_pend_next = a_frame_end_reg;
            found_next        = a_frame_end_reg ? '0 : found_bumped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg        <= '0;
            b_match_pend_reg <= 1'b0;
            b_total_pend_reg <= 1'b0;
        end else begin
            found_reg        <= found_next;
            b_match_pend_reg <= b_match_pend_next;
            b_total_pend_reg <= b_total_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_move) begin
            b_count_reg <= found_bumped;
            b_col_reg   <= POS_W'(a_col_reg);
            b_row_reg   <= POS_W'(a_row_reg);
        end
    end

    // Match report goes first, then the frame total
    assign m_result_kind  = b_match_pend_reg ? RESULT_MATCH : RESULT_TOTAL;
    assign m_match_column = b_match_pend_reg ? b_col_reg : '0;
    assign m_match_row    = b_match_pend_reg ? b_row_reg : '0;
    assign m_match_total  = b_count_reg;
    assign m_last_of_run  = !(b_match_pend_reg && b_total_pend_reg);

endmodule

// ===== tb/grid_2x2_pattern_matcher_core_test.sv =====
// Testbench for the 2x2 grid pattern matcher core: match predictor, cell stimulus, result checks.
`timescale 1ns / 1ps

module grid_2x2_pattern_matcher_core_test;
    import g2pm_pkg::*;

    localparam int LINE_MAX     = 64;
    localparam int HEIGHT_MAX   = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int REPORT_CAP   = 200;
    localparam int RANDOM_CELLS = 850;

    // index values with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam color_t RED    = 3'd0;
    localparam color_t GREEN  = 3'd1;
    localparam color_t BLUE   = 3'd2;
    localparam color_t YELLOW = 3'd3;
    localparam color_t WHITE  = 3'd4;

    typedef struct packed {
        logic               kind;
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   row;
        logic [COUNT_W-1:0] total;
        logic               last;
    } match_report_t;

    class match_tracker;
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        color_t            pat_tl;
        color_t            pat_tr;
        color_t            pat_bl;
        color_t            pat_br;
        color_t            line_buf [LINE_MAX];
        color_t            left_color;
        int unsigned       col_idx;
        int unsigned       row_idx;
        int unsigned       found;
        match_report_t     due_reports [$];
        int unsigned       errors;

        function new();
            width_reg  = SIZE_W'(2);
            height_reg = SIZE_W'(2);
            pat_tl     = RED;
            pat_tr     = RED;
            pat_bl     = RED;
            pat_br     = RED;
            foreach (line_buf[i]) line_buf[i] = RED;
            left_color = RED;
            col_idx    = 0;
            row_idx    = 0;
            found      = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GRID_WIDTH:           width_reg = data;
                REG_GRID_HEIGHT:          height_reg = data;
                REG_PATTERN_TOP_LEFT:     pat_tl = data[COLOR_W-1:0];
                REG_PATTERN_TOP_RIGHT:    pat_tr = data[COLOR_W-1:0];
                REG_PATTERN_BOTTOM_LEFT:  pat_bl = data[COLOR_W-1:0];
                REG_PATTERN_BOTTOM_RIGHT: pat_br = data[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned frame_width();
            if (width_reg < 2) return 2;
            if (width_reg > LINE_MAX) return LINE_MAX;
            return width_reg;
        endfunction

        function int unsigned frame_height();
            if (height_reg < 2) return 2;
            if (height_reg > HEIGHT_MAX) return HEIGHT_MAX;
            return height_reg;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // Advance the window by one cell and queue the reports it causes.
        function void note_cell(color_t new_color);
            int unsigned   w;
            int unsigned   h;
            int unsigned   c;
            bit            end_col;
            bit            end_row;
            bit            frame_done;
            match_report_t rep;
            w          = frame_width();
            h          = frame_height();
            c          = col_idx;
            end_col    = (col_idx >= w - 1);
            end_row    = (row_idx >= h - 1);
            frame_done = end_col && end_row;
            if (c >= LINE_MAX) c = LINE_MAX - 1;

            if (c >= 1 && row_idx >= 1 && line_buf[c-1] == pat_tl && line_buf[c] == pat_tr &&
                left_color == pat_bl && new_color == pat_br) begin
                if (found < COUNT_MAX) found++;
                rep.kind   = RESULT_MATCH;
                rep.column = POS_W'(c);
                rep.row    = POS_W'(row_idx);
                rep.total  = COUNT_W'(found);
                rep.last   = !frame_done;
                due_reports = {due_reports, rep};
            end

            // line buffer trails by one column; the last column also stores itself
            if (c >= 1) line_buf[c-1] = left_color;
            if (end_col) line_buf[c] = new_color;
            left_color = new_color;

            if (frame_done) begin
                rep.kind   = RESULT_TOTAL;
                rep.column = '0;
                rep.row    = '0;
                rep.total  = COUNT_W'(found);
                rep.last   = 1'b1;
                due_reports = {due_reports, rep};
                col_idx = 0;
                row_idx = 0;
                found   = 0;
            end else if (end_col) begin
                col_idx = 0;
                row_idx = row_idx + 1;
            end else begin
                col_idx = c + 1;
            end
        endfunction

        function void check_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
            if (got !== want) begin
                if (errors < REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(match_report_t got);
            match_report_t want;
            if (due_reports.size() == 0) begin
                if (errors < REPORT_CAP)
                    $error("result beat with nothing pending: kind %0d total %0d",
                           got.kind, got.total);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            check_field("result_kind", COUNT_W'(want.kind), COUNT_W'(got.kind));
            check_field("match_column", COUNT_W'(want.column), COUNT_W'(got.column));
            check_field("match_row", COUNT_W'(want.row), COUNT_W'(got.row));
            check_field("match_total", want.total, got.total);
            check_field("last_of_run", COUNT_W'(want.last), COUNT_W'(got.last));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [COLOR_W-1:0]    s_cell_color = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_result_kind;
    logic [POS_W-1:0]      m_match_column;
    logic [POS_W-1:0]      m_match_row;
    logic [COUNT_W-1:0]    m_match_total;
    logic                  m_last_of_run;

    match_tracker board;
    color_t       frame_buf [LINE_MAX*HEIGHT_MAX];
    bit           sender_idle = 1'b1;
    int           hold_asked = 0;
    int           random_cells = 0;
    int           cycle_count = 0;

    grid_2x2_pattern_matcher_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cell_color   (s_cell_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_match_column (m_match_column),
        .m_match_row    (m_match_row),
        .m_match_total  (m_match_total),
        .m_last_of_run  (m_last_of_run)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_result_kind, m_match_column, m_match_row,
                                 m_match_total, m_last_of_run});
    end

    // Result side: runs of ready with random stalls, plus one long hold on request.
    initial begin
        int run_left;
        int stall_left;
        int hold_seen;
        int r;
        run_left   = 0;
        stall_left = 0;
        hold_seen  = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_asked != hold_seen) begin
                hold_seen  = hold_asked;
                run_left   = 0;
                stall_left = LONG_HOLD;
            end
            if (run_left == 0 && stall_left == 0) begin
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 150)
                                                       : $urandom_range(1, 8);
                r = $urandom_range(0, 99);
                if (r < 40)      stall_left = 0;
                else if (r < 80) stall_left = $urandom_range(1, 3);
                else if (r < 95) stall_left = $urandom_range(4, 12);
                else             stall_left = $urandom_range(20, 60);
            end
            if (run_left > 0) begin
                m_ready <= 1'b1;
                run_left--;
            end else begin
                m_ready <= 1'b0;
                stall_left--;
            end
            @(posedge aclk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic color_t pick_pattern_color();
        if ($urandom_range(0, 7) == 0) return color_t'($urandom_range(5, 7));
        return color_t'($urandom_range(0, 4));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        board.write_reg(idx, data);
    endtask

    // Offer one cell and hold it until the beat is taken.
    task automatic send_cell(color_t c);
        int gap;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cell_color <= c;
        do @(posedge aclk); while (!s_ready);
        board.note_cell(c);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Build a whole frame of noise, optionally stamped with copies of the pattern, and send it.
    task automatic send_frame(bit stamped);
        int w;
        int h;
        int n;
        int r;
        int c;
        w = board.frame_width();
        h = board.frame_height();
        for (int i = 0; i < w * h; i++)
            frame_buf[i] = ($urandom_range(0, 9) == 0) ? color_t'($urandom_range(0, 7))
                                                       : color_t'($urandom_range(0, 4));
        if (stamped) begin
            n = (w - 1) * (h - 1) / 2 + 1;
            repeat (n) begin
                r = $urandom_range(0, h - 2);
                c = $urandom_range(0, w - 2);
                frame_buf[r*w + c]       = board.pat_tl;
                frame_buf[r*w + c + 1]   = board.pat_tr;
                frame_buf[(r+1)*w + c]   = board.pat_bl;
                frame_buf[(r+1)*w + c+1] = board.pat_br;
            end
        end
        for (int i = 0; i < w * h; i++) begin
            send_cell(frame_buf[i]);
            random_cells++;
        end
    endtask

    initial begin
        int phase;
        int frames;
        board = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: 2x2 frame, all-red pattern; match and total on the same cell
        send_cell(RED);
        send_cell(RED);
        send_cell(RED);
        send_cell(RED);
        wait_drained();

        // sizes below range clamp to 2; raw colours 5..7; spare indexes ignored
        write_reg(REG_GRID_WIDTH, 7'd0);
        write_reg(REG_GRID_HEIGHT, 7'd1);
        write_reg(REG_PATTERN_TOP_LEFT, 7'h7F);
        write_reg(REG_PATTERN_TOP_RIGHT, 7'd5);
        write_reg(REG_PATTERN_BOTTOM_LEFT, 7'd6);
        write_reg(REG_PATTERN_BOTTOM_RIGHT, 7'd7);
        write_reg(REG_UNMAPPED_LO, 7'h55);
        write_reg(REG_UNMAPPED_HI, 7'h2A);
        send_cell(color_t'(7));
        send_cell(color_t'(5));
        send_cell(color_t'(6));
        send_cell(color_t'(7));
        send_cell(YELLOW);
        send_cell(WHITE);
        send_cell(YELLOW);
        send_cell(WHITE);
        wait_drained();

        // two matches in a 5x4 frame, then shrink the size with the counters past it
        write_reg(REG_GRID_WIDTH, 7'd5);
        write_reg(REG_GRID_HEIGHT, 7'd4);
        write_reg(REG_PATTERN_TOP_LEFT, CFG_DATA_W'(GREEN));
        write_reg(REG_PATTERN_TOP_RIGHT, CFG_DATA_W'(BLUE));
        write_reg(REG_PATTERN_BOTTOM_LEFT, CFG_DATA_W'(YELLOW));
        write_reg(REG_PATTERN_BOTTOM_RIGHT, CFG_DATA_W'(WHITE));
        send_cell(GREEN);
        send_cell(BLUE);
        send_cell(GREEN);
        send_cell(BLUE);
        send_cell(RED);
        send_cell(YELLOW);
        send_cell(WHITE);
        send_cell(YELLOW);
        send_cell(WHITE);
        send_cell(RED);
        send_cell(GREEN);
        send_cell(BLUE);
        wait_drained();
        write_reg(REG_GRID_WIDTH, 7'd2);
        write_reg(REG_GRID_HEIGHT, 7'd2);
        send_cell(RED);

        phase = 0;
        while (random_cells < RANDOM_CELLS) begin
            wait_drained();
            case (phase)
                0: begin
                    write_reg(REG_GRID_WIDTH, 7'd127);
                    write_reg(REG_GRID_HEIGHT, 7'd0);
                end
                1: begin
                    write_reg(REG_GRID_WIDTH, 7'd1);
                    write_reg(REG_GRID_HEIGHT, 7'd64);
                end
                2: begin
                    write_reg(REG_GRID_WIDTH, 7'd64);
                    write_reg(REG_GRID_HEIGHT, 7'd2);
                end
                default: begin
                    write_reg(REG_GRID_WIDTH, CFG_DATA_W'($urandom_range(0, 9)));
                    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
                end
            endcase
            // upper data bits carry junk; only the low colour bits count
            write_reg(REG_PATTERN_TOP_LEFT, {4'($urandom_range(0, 15)), pick_pattern_color()});
            write_reg(REG_PATTERN_TOP_RIGHT, {4'($urandom_range(0, 15)), pick_pattern_color()});
            write_reg(REG_PATTERN_BOTTOM_LEFT, {4'($urandom_range(0, 15)), pick_pattern_color()});
            write_reg(REG_PATTERN_BOTTOM_RIGHT, {4'($urandom_range(0, 15)), pick_pattern_color()});
            sender_idle = ($urandom_range(0, 3) != 0);
            // long receiver hold while a wide frame keeps streaming in
            if (phase == 0) hold_asked++;
            frames = (phase < 3) ? 1 : $urandom_range(1, 3);
            repeat (frames) send_frame($urandom_range(0, 5) != 0);
            phase++;
        end

        wait_drained();
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/g2pm_pkg.sv
rtl/g2pm_window_cell.sv
rtl/g2pm_line_buf.sv
rtl/grid_2x2_pattern_matcher_core.sv
tb/grid_2x2_pattern_matcher_core_test.sv
